FILE: rtl/bfa_pkg.sv
// Shared types and constants of the best-fit block allocator.
package bfa_pkg;

	// Field widths fixed by the item format
	localparam int FUNC_W  = 2;
	localparam int IDX_W   = 4;
	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 24;
	localparam int KIND_W  = 2;
	localparam int CFG_W   = 5;

	// Default table depth and the largest count a scan may use
	localparam int ENTRIES_DEF = 16;
	localparam int SCAN_MAX    = 16;

	// Entry count after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// Operation codes of an input item
	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_ALLOC = 2'd1,
		FUNC_DUMP  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Kinds of result beat
	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_BLOCK = 2'd1,
		KIND_NONE  = 2'd2,
		KIND_RSVD  = 2'd3
	} kind_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/best_fit_block_allocator.sv
// Best-fit block allocator: free-block table, scan sequencer and result register.
//
// Usage: drive func and its operand ports with start high; the item is taken at
// the rising edge where start is high and busy is low. A load (func 0) writes one
// table entry at that edge and leaves busy low; func 3 is taken and ignored.
// An allocate (func 1) or dump (func 2) raises busy while the sequencer runs
//   MOD, SCAN, DRAIN and FINISH; N = used entry count (1..USED), and MOD brings
//   the roving pointer below N only if the count was lowered since the last scan.
// The scan reads one table entry per cycle through a single registered memory
// read port and one compare unit. An allocate gives one result beat in the cycle
// after busy falls. A dump gives one beat per live entry while it scans, the last
// one in the cycle after busy falls, or a single "none" beat. Each beat is shown
// for one cycle with result_valid high; the receiver cannot hold it, so nothing
// stalls. The entry count register is written through cfg_we/cfg_data; the user
// must write it only while idle, as the block itself does not enforce this. Reset
// clears every live flag, the roving pointer and the sequencer, and sets the
// entry count to 16. Table contents are undefined until loaded.
module best_fit_block_allocator #(
	parameter int ENTRIES = bfa_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bfa_pkg::FUNC_W-1:0]    func,
	input  logic [bfa_pkg::IDX_W-1:0]     entry_index,
	input  logic [bfa_pkg::ADDR_W-1:0]    block_address,
	input  logic [bfa_pkg::LEN_W-1:0]     block_length,
	input  logic [bfa_pkg::LEN_W-1:0]     request_size,
	input  logic                          cfg_we,
	input  logic [bfa_pkg::CFG_W-1:0]     cfg_data,
	output logic                          result_valid,
	output logic [bfa_pkg::KIND_W-1:0]    result_kind,
	output logic                          granted,
	output logic [bfa_pkg::IDX_W-1:0]     chosen_entry,
	output logic [bfa_pkg::LEN_W-1:0]     remaining_length,
	output logic [bfa_pkg::ADDR_W-1:0]    start_address,
	output logic                          last_of_run
);

	// Entries reachable through the index field
	localparam int USED = (ENTRIES < bfa_pkg::SCAN_MAX) ? ENTRIES : bfa_pkg::SCAN_MAX;
	localparam int IW   = $clog2(USED);
	localparam int CW   = $clog2(USED + 1);
	localparam logic [bfa_pkg::CFG_W-1:0] USED_C = bfa_pkg::CFG_W'(USED);

	// Control state
	bfa_pkg::state_t          state_q, state_d;
	logic [bfa_pkg::CFG_W-1:0] count_q;
	logic [USED-1:0]          live_q;
	logic [IW-1:0]            rover_q;
	logic [IW-1:0]            ptr_q;
	logic [CW-1:0]            nread_q;
	logic                     is_alloc_q;
	logic                     found_q;
	logic                     vld_s1;
	logic                     res_valid_q;

	// Payload registers
	logic [bfa_pkg::LEN_W-1:0]  req_q;
	logic [IW-1:0]              tag_s1;
	logic [bfa_pkg::ADDR_W-1:0] addr_s1;
	logic [bfa_pkg::LEN_W-1:0]  len_s1;
	logic [IW-1:0]              best_q;
	logic [bfa_pkg::LEN_W-1:0]  bestlen_q;
	logic [bfa_pkg::ADDR_W-1:0] bestaddr_q;
	logic [bfa_pkg::KIND_W-1:0] kind_q;
	logic                       granted_q;
	logic [bfa_pkg::IDX_W-1:0]  chosen_q;
	logic [bfa_pkg::LEN_W-1:0]  remain_q;
	logic [bfa_pkg::ADDR_W-1:0] saddr_q;
	logic                       last_q;

	// Table memory
	logic [bfa_pkg::ADDR_W-1:0] mem_addr [USED];
	logic [bfa_pkg::LEN_W-1:0]  mem_len  [USED];

	// Combinational control and datapath
	logic                       accept;
	logic                       load_ok;
	logic [bfa_pkg::CFG_W-1:0]  cnt_full;
	logic [CW-1:0]              cnt;
	logic [CW-1:0]              ptr_p1;
	logic [IW-1:0]              ptr_next;
	logic [CW-1:0]              ptr_sub;
	logic [CW-1:0]              best_p1;
	logic [IW-1:0]              best_next;
	logic                       ptr_high;
	logic                       issue;
	logic                       finish;
	logic                       mod_step;
	logic                       tag_live;
	logic                       fits;
	logic [bfa_pkg::LEN_W-1:0]  diff;
	logic                       emit;
	bfa_pkg::kind_t             emit_kind;
	logic                       emit_granted;
	logic [IW-1:0]              emit_entry;
	logic [bfa_pkg::LEN_W-1:0]  emit_len;
	logic [bfa_pkg::ADDR_W-1:0] emit_addr;
	logic                       emit_last;
	logic                       wr_len;
	logic                       wr_adr;
	logic [IW-1:0]              wr_idx;
	logic [bfa_pkg::LEN_W-1:0]  wr_len_data;

	assign busy   = (state_q != bfa_pkg::ST_IDLE);
	assign accept = start && !busy;

	// Clamp the entry count to 1..USED
	always_comb begin
		if (count_q == '0) begin
			cnt_full = bfa_pkg::CFG_W'(1);
		end else if (count_q > USED_C) begin
			cnt_full = USED_C;
		end else begin
			cnt_full = count_q;
		end
	end
	assign cnt = cnt_full[CW-1:0];

	// Rotating index arithmetic
	assign ptr_p1    = CW'(ptr_q) + CW'(1);
	assign ptr_next  = (ptr_p1 == cnt) ? '0 : ptr_p1[IW-1:0];
	assign ptr_sub   = CW'(ptr_q) - cnt;
	assign best_p1   = CW'(best_q) + CW'(1);
	assign best_next = (best_p1 == cnt) ? '0 : best_p1[IW-1:0];
	assign ptr_high  = (CW'(ptr_q) >= cnt);

	assign load_ok = accept && (bfa_pkg::func_t'(func) == bfa_pkg::FUNC_LOAD)
		&& ({1'b0, entry_index} < USED_C);

	// Next state and sequencer strobes
	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		finish   = 1'b0;
		mod_step = 1'b0;
		unique case (state_q)
			bfa_pkg::ST_IDLE: begin
				if (accept && (bfa_pkg::func_t'(func) == bfa_pkg::FUNC_ALLOC
					|| bfa_pkg::func_t'(func) == bfa_pkg::FUNC_DUMP)) begin
					state_d = bfa_pkg::ST_MOD;
				end
			end
			bfa_pkg::ST_MOD: begin
				if (ptr_high) begin
					mod_step = 1'b1;
				end else begin
					state_d = bfa_pkg::ST_SCAN;
				end
			end
			bfa_pkg::ST_SCAN: begin
				issue = 1'b1;
				if (nread_q + CW'(1) == cnt) begin
					state_d = bfa_pkg::ST_DRAIN;
				end
			end
			bfa_pkg::ST_DRAIN: begin
				state_d = bfa_pkg::ST_FINISH;
			end
			bfa_pkg::ST_FINISH: begin
				finish  = 1'b1;
				state_d = bfa_pkg::ST_IDLE;
			end
			default: begin
				state_d = bfa_pkg::ST_IDLE;
			end
		endcase
	end

	// Compare unit on the entry read last cycle
	assign tag_live = live_q[tag_s1];
	assign fits     = tag_live && (len_s1 >= req_q) && (!found_q || len_s1 < bestlen_q);
	assign diff     = bestlen_q - req_q;

	// Result beat and table update selection
	always_comb begin
		emit         = 1'b0;
		emit_kind    = bfa_pkg::KIND_ALLOC;
		emit_granted = 1'b0;
		emit_entry   = best_q;
		emit_len     = bestlen_q;
		emit_addr    = bestaddr_q;
		emit_last    = 1'b0;
		wr_len       = 1'b0;
		wr_adr       = 1'b0;
		wr_idx       = entry_index[IW-1:0];
		wr_len_data  = block_length;
		if (load_ok) begin
			wr_len = 1'b1;
			wr_adr = 1'b1;
		end
		if (vld_s1 && !is_alloc_q && tag_live && found_q) begin
			// A later live block exists: release the held one as not last
			emit      = 1'b1;
			emit_kind = bfa_pkg::KIND_BLOCK;
		end
		if (finish) begin
			emit      = 1'b1;
			emit_last = 1'b1;
			if (is_alloc_q) begin
				emit_kind = bfa_pkg::KIND_ALLOC;
				if (found_q) begin
					emit_granted = 1'b1;
					emit_len     = diff;
					wr_len       = 1'b1;
					wr_idx       = best_q;
					wr_len_data  = diff;
				end else begin
					emit_entry = '0;
					emit_len   = '0;
					emit_addr  = '0;
				end
			end else if (found_q) begin
				emit_kind = bfa_pkg::KIND_BLOCK;
			end else begin
				emit_kind  = bfa_pkg::KIND_NONE;
				emit_entry = '0;
				emit_len   = '0;
				emit_addr  = '0;
			end
		end
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= bfa_pkg::CFG_RESET;
			live_q      <= '0;
			rover_q     <= '0;
			ptr_q       <= '0;
			nread_q     <= '0;
			is_alloc_q  <= 1'b0;
			found_q     <= 1'b0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			vld_s1      <= issue;
			res_valid_q <= emit;
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (load_ok) begin
				live_q[entry_index[IW-1:0]] <= 1'b1;
			end
			if (accept) begin
				ptr_q      <= rover_q;
				nread_q    <= '0;
				found_q    <= 1'b0;
				is_alloc_q <= (bfa_pkg::func_t'(func) == bfa_pkg::FUNC_ALLOC);
			end
			if (mod_step) begin
				ptr_q <= ptr_sub[IW-1:0];
			end
			if (issue) begin
				ptr_q   <= ptr_next;
				nread_q <= nread_q + CW'(1);
			end
			if (vld_s1 && (is_alloc_q ? fits : tag_live)) begin
				found_q <= 1'b1;
			end
			if (finish && is_alloc_q && found_q) begin
				if (diff != '0) begin
					rover_q <= best_q;
				end else begin
					live_q[best_q] <= 1'b0;
					rover_q        <= best_next;
				end
			end
		end
	end

	// Hold payload: request, best or pending entry, result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request_size;
		end
		tag_s1 <= ptr_q;
		if (vld_s1 && (is_alloc_q ? fits : tag_live)) begin
			best_q     <= tag_s1;
			bestlen_q  <= len_s1;
			bestaddr_q <= addr_s1;
		end
		if (emit) begin
			kind_q    <= emit_kind;
			granted_q <= emit_granted;
			chosen_q  <= bfa_pkg::IDX_W'(emit_entry);
			remain_q  <= emit_len;
			saddr_q   <= emit_addr;
			last_q    <= emit_last;
		end
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_len) begin
			mem_len[wr_idx] <= wr_len_data;
		end
		if (wr_adr) begin
			mem_addr[wr_idx] <= block_address;
		end
		if (issue) begin
			len_s1  <= mem_len[ptr_q];
			addr_s1 <= mem_addr[ptr_q];
		end
	end

	assign result_valid     = res_valid_q;
	assign result_kind      = kind_q;
	assign granted          = granted_q;
	assign chosen_entry     = chosen_q;
	assign remaining_length = remain_q;
	assign start_address    = saddr_q;
	assign last_of_run      = last_q;

	// Nothing is emitted from an idle cycle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !result_valid)
		else $error("result beat follows an idle cycle");

	// An allocate answer is always the only beat of its run
	a_alloc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == bfa_pkg::KIND_ALLOC) |-> last_of_run)
		else $error("allocate answer without last marker");

	// A run ends with a gap before the next beat
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |=> !result_valid)
		else $error("beat right after the last of a run");

	// The scan pointer stays inside the used count
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfa_pkg::ST_SCAN) |-> (CW'(ptr_q) < cnt))
		else $error("scan pointer beyond entry count");

	// An empty dump reports zero fields and ends the run
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == bfa_pkg::KIND_NONE)
		|-> (last_of_run && chosen_entry == '0 && !granted))
		else $error("malformed empty dump beat");

endmodule
